// ----- hdl/sts_pkg.sv -----
// ----------------------------------------------------------------------------
// SQL token scanner package
// Shared types, character codes and classification helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package sts_pkg;

   localparam logic [7:0] MAX_TEXT = 8'd255;
   localparam logic [7:0] KW_BYTES = 8'd7;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_QUOTE = 8'h27;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_UNDER = 8'h5F;

   localparam logic [2:0] TK_EOF     = 3'd0;
   localparam logic [2:0] TK_KEYWORD = 3'd1;
   localparam logic [2:0] TK_IDENT   = 3'd2;
   localparam logic [2:0] TK_INTEGER = 3'd3;
   localparam logic [2:0] TK_STRING  = 3'd4;
   localparam logic [2:0] TK_SYMBOL  = 3'd5;

   localparam logic [8:0] SYM_LE = 9'd256;
   localparam logic [8:0] SYM_GE = 9'd257;
   localparam logic [8:0] SYM_NE = 9'd258;

   localparam logic RK_TEXT  = 1'b0;
   localparam logic RK_TOKEN = 1'b1;

   typedef enum logic [2:0] {
      MODE_IDLE     = 3'd0,
      MODE_COMMENT  = 3'd1,
      MODE_WORD     = 3'd2,
      MODE_NUMBER   = 3'd3,
      MODE_STRING   = 3'd4,
      MODE_SKIP     = 3'd5,
      MODE_SKIP_STR = 3'd6,
      MODE_SPARE    = 3'd7
   } mode_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  ch;
      logic [2:0]  tok;
      logic [5:0]  kw;
      logic [8:0]  sym;
      logic [31:0] val;
      logic [15:0] line;
      logic [15:0] col;
   } rec_type;

   typedef struct packed {
      logic [2:0]          cnt;
      rec_type [3:0]       recs;
   } bundle_type;

   typedef struct packed {
      logic [15:0] line;
      logic [15:0] col;
   } pos_type;

   // Keywords, right-justified: the first character sits in the top byte used.
   localparam logic [55:0] KEYWORD_SET [32] = '{
      56'("SELECT"), 56'("INSERT"), 56'("UPDATE"), 56'("DELETE"), 56'("CREATE"),
      56'("DROP"), 56'("TABLE"), 56'("INDEX"), 56'("FROM"), 56'("WHERE"),
      56'("INTO"), 56'("VALUES"), 56'("SET"), 56'("ORDER"), 56'("BY"),
      56'("LIMIT"), 56'("PRIMARY"), 56'("KEY"), 56'("INTEGER"), 56'("TEXT"),
      56'("BLOB"), 56'("NULL"), 56'("AND"), 56'("OR"), 56'("NOT"), 56'("ASC"),
      56'("DESC"), 56'("COUNT"), 56'("SUM"), 56'("AVG"), 56'("MIN"), 56'("MAX")
   };

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || c == CH_UNDER;
   endfunction

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
   endfunction

   function automatic logic [5:0] keyword_lookup(input logic [55:0] buffer,
                                                 input logic [7:0] len);
      logic [5:0] code;
      code = 6'd0;
      if (len != 8'd0 && len <= KW_BYTES) begin
         for (int k = 0; k < 32; k++) begin
            if (buffer == KEYWORD_SET[k]) begin
               code = 6'(k + 1);
            end
         end
      end
      return code;
   endfunction

   function automatic pos_type advance_pos(input logic [7:0] c, input pos_type p);
      pos_type q;
      q = p;
      if (c == CH_LF) begin
         if (p.line != 16'hFFFF) q.line = p.line + 16'd1;
         q.col = 16'd1;
      end else if (c != CH_NUL && p.col != 16'hFFFF) begin
         q.col = p.col + 16'd1;
      end
      return q;
   endfunction

   function automatic rec_type make_text(input logic [7:0] c);
      rec_type r;
      r = '0;
      r.kind = RK_TEXT;
      r.ch = c;
      return r;
   endfunction

   function automatic rec_type make_token(input logic [2:0] tok, input logic [5:0] kw,
                                          input logic [8:0] sym, input logic [31:0] val,
                                          input pos_type p);
      rec_type r;
      r = '0;
      r.kind = RK_TOKEN;
      r.tok = tok;
      r.kw = kw;
      r.sym = sym;
      r.val = val;
      r.line = p.line;
      r.col = p.col;
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/sql_token_scanner.sv -----
// ----------------------------------------------------------------------------
// SQL token scanner
// Streaming SQL lexer: one text byte in, text and token results out.
//
// Input: a byte is taken on a clock edge with req_push high and req_full low.
// Byte 0 ends a text. Each byte is scanned when the following byte arrives,
// so the first byte after reset yields nothing until its successor comes.
// A byte yields zero to four result beats; rsp_final_result marks the last.
// Output: the oldest result is on the rsp_ ports while rsp_empty is low and
// is taken on an edge with rsp_pop high. A stalled receiver holds results in
// the output register and a two-bundle queue; req_full rises once both
// queue entries are taken and the output register is busy.
// A scanned byte's results enter the queue on the edge that accepted its
// successor and pass from there into the output register. Throughput: one
// byte per cycle into the scanner while req_full is low; the output drains
// one beat per cycle while rsp_pop is held high.
// Reset clears the scanner state and empties the queue and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sql_token_scanner
   import sts_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_text_byte,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic             rsp_result_kind,
   output logic [7:0]       rsp_char_out,
   output logic [2:0]       rsp_token_kind,
   output logic [5:0]       rsp_keyword_code,
   output logic [8:0]       rsp_symbol_code,
   output logic signed [31:0] rsp_number_value,
   output logic [15:0]      rsp_start_line,
   output logic [15:0]      rsp_start_column,
   output logic             rsp_final_result
);

   logic       accept;
   logic       bundle_push;
   bundle_type bundle;
   logic       q_full;
   logic       q_pop;
   bundle_type q_head;
   logic       q_empty;
   logic       out_valid;
   rec_type    out_rec;
   logic       out_final;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   sts_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .text_byte   (req_text_byte),
      .bundle_push (bundle_push),
      .bundle      (bundle)
   );

   sts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (bundle_push),
      .push_data (bundle),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   sts_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .head_empty (q_empty),
      .head_pop   (q_pop),
      .out_pop    (rsp_pop),
      .out_valid  (out_valid),
      .out_rec    (out_rec),
      .out_final  (out_final)
   );

   assign rsp_empty        = !out_valid;
   assign rsp_result_kind  = out_rec.kind;
   assign rsp_char_out     = out_rec.ch;
   assign rsp_token_kind   = out_rec.tok;
   assign rsp_keyword_code = out_rec.kw;
   assign rsp_symbol_code  = out_rec.sym;
   assign rsp_number_value = $signed(out_rec.val);
   assign rsp_start_line   = out_rec.line;
   assign rsp_start_column = out_rec.col;
   assign rsp_final_result = out_final;

endmodule

`default_nettype wire

// ----- hdl/sts_front.sv -----
// ----------------------------------------------------------------------------
// SQL token scanner front end
// Holds the lookahead byte, runs the scan step and emits at most one bundle of
// up to four result records per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_front
   import sts_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] text_byte,
   output logic            bundle_push,
   output bundle_type      bundle
);

   logic [7:0]  held_ff, held_in;
   logic        held_valid_ff, held_valid_in;
   mode_type    mode_ff, mode_in;
   logic [7:0]  len_ff, len_in;
   logic [55:0] kwbuf_ff, kwbuf_in;
   logic [31:0] acc_ff, acc_in;
   logic        minus_ff, minus_in;
   pos_type     pos_ff, pos_in;
   pos_type     tpos_ff, tpos_in;

   logic [7:0]    c, n;
   logic          idle_go;
   logic [8:0]    sym;
   logic [2:0]    cnt;
   rec_type [3:0] recs;
   logic [5:0]    kw;

   assign c = held_ff;
   assign n = text_byte;

   always_comb begin
      mode_in  = mode_ff;
      len_in   = len_ff;
      kwbuf_in = kwbuf_ff;
      acc_in   = acc_ff;
      minus_in = minus_ff;
      pos_in   = pos_ff;
      tpos_in  = tpos_ff;
      cnt      = 3'd0;
      recs     = '0;
      idle_go  = 1'b0;
      sym      = {1'b0, c};
      kw       = keyword_lookup(kwbuf_ff, len_ff);

      unique case (mode_ff)
         MODE_COMMENT: begin
            if (c == CH_LF || c == CH_NUL) idle_go = 1'b1;
            else pos_in = advance_pos(c, pos_in);
         end
         MODE_WORD: begin
            if (is_word(c) && len_in < MAX_TEXT) begin
               if (len_in < KW_BYTES) kwbuf_in = {kwbuf_in[47:0], to_upper(c)};
               len_in = len_in + 8'd1;
               recs[cnt[1:0]] = make_text(c);
               cnt = cnt + 3'd1;
               pos_in = advance_pos(c, pos_in);
            end else begin
               recs[cnt[1:0]] = make_token((kw != 6'd0) ? TK_KEYWORD : TK_IDENT, kw,
                                           9'd0, 32'd0, tpos_in);
               cnt = cnt + 3'd1;
               idle_go = 1'b1;
            end
         end
         MODE_NUMBER: begin
            if (is_digit(c) && len_in < MAX_TEXT) begin
               acc_in = {acc_in[28:0], 3'b000} + {acc_in[30:0], 1'b0} + {28'd0, c[3:0]};
               len_in = len_in + 8'd1;
               recs[cnt[1:0]] = make_text(c);
               cnt = cnt + 3'd1;
               pos_in = advance_pos(c, pos_in);
            end else begin
               recs[cnt[1:0]] = make_token(TK_INTEGER, 6'd0, 9'd0,
                                           minus_in ? (32'd0 - acc_in) : acc_in, tpos_in);
               cnt = cnt + 3'd1;
               idle_go = 1'b1;
            end
         end
         MODE_STRING: begin
            if (c == CH_NUL || len_in >= MAX_TEXT) begin
               recs[cnt[1:0]] = make_token(TK_STRING, 6'd0, 9'd0, 32'd0, tpos_in);
               cnt = cnt + 3'd1;
               idle_go = 1'b1;
            end else if (c == CH_QUOTE) begin
               if (n == CH_QUOTE) begin
                  recs[cnt[1:0]] = make_text(c);
                  cnt = cnt + 3'd1;
                  len_in = len_in + 8'd1;
                  mode_in = MODE_SKIP_STR;
               end else begin
                  recs[cnt[1:0]] = make_token(TK_STRING, 6'd0, 9'd0, 32'd0, tpos_in);
                  cnt = cnt + 3'd1;
                  mode_in = MODE_IDLE;
               end
               pos_in = advance_pos(c, pos_in);
            end else begin
               recs[cnt[1:0]] = make_text(c);
               cnt = cnt + 3'd1;
               len_in = len_in + 8'd1;
               pos_in = advance_pos(c, pos_in);
            end
         end
         MODE_SKIP: begin
            pos_in = advance_pos(c, pos_in);
            mode_in = MODE_IDLE;
         end
         MODE_SKIP_STR: begin
            pos_in = advance_pos(c, pos_in);
            mode_in = MODE_STRING;
         end
         MODE_IDLE, MODE_SPARE: begin
            idle_go = 1'b1;
         end
      endcase

      // Scan between tokens, after any token that the byte has just closed.
      if (idle_go) begin
         mode_in = MODE_IDLE;
         if (c == CH_NUL) begin
            tpos_in = pos_in;
            recs[cnt[1:0]] = make_token(TK_EOF, 6'd0, 9'd0, 32'd0, tpos_in);
            cnt = cnt + 3'd1;
            pos_in = '{line: 16'd1, col: 16'd1};
            len_in = 8'd0;
         end else if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
            pos_in = advance_pos(c, pos_in);
         end else if (c == CH_MINUS && n == CH_MINUS) begin
            mode_in = MODE_COMMENT;
            pos_in = advance_pos(c, pos_in);
         end else begin
            tpos_in  = pos_in;
            len_in   = 8'd0;
            kwbuf_in = '0;
            acc_in   = '0;
            minus_in = 1'b0;
            if (is_alpha(c) || c == CH_UNDER) begin
               mode_in = MODE_WORD;
               kwbuf_in = {48'd0, to_upper(c)};
               len_in = 8'd1;
               recs[cnt[1:0]] = make_text(c);
               cnt = cnt + 3'd1;
            end else if (is_digit(c) || (c == CH_MINUS && is_digit(n))) begin
               mode_in = MODE_NUMBER;
               if (c == CH_MINUS) minus_in = 1'b1;
               else acc_in = {28'd0, c[3:0]};
               len_in = 8'd1;
               recs[cnt[1:0]] = make_text(c);
               cnt = cnt + 3'd1;
            end else if (c == CH_QUOTE) begin
               mode_in = MODE_STRING;
            end else begin
               if (c == CH_LT && n == CH_EQ) sym = SYM_LE;
               else if (c == CH_GT && n == CH_EQ) sym = SYM_GE;
               else if (c == CH_BANG && n == CH_EQ) sym = SYM_NE;
               else if (c == CH_LT && n == CH_GT) sym = SYM_NE;
               recs[cnt[1:0]] = make_text(c);
               cnt = cnt + 3'd1;
               if (sym[8]) begin
                  recs[cnt[1:0]] = make_text(n);
                  cnt = cnt + 3'd1;
                  mode_in = MODE_SKIP;
               end
               recs[cnt[1:0]] = make_token(TK_SYMBOL, 6'd0, sym, 32'd0, tpos_in);
               cnt = cnt + 3'd1;
            end
            pos_in = advance_pos(c, pos_in);
         end
      end
   end

   assign held_in       = text_byte;
   assign held_valid_in = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff       <= 8'd0;
         held_valid_ff <= 1'b0;
         mode_ff       <= MODE_IDLE;
         len_ff        <= 8'd0;
         kwbuf_ff      <= '0;
         acc_ff        <= '0;
         minus_ff      <= 1'b0;
         pos_ff        <= '{line: 16'd1, col: 16'd1};
         tpos_ff       <= '{line: 16'd1, col: 16'd1};
      end else if (accept) begin
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         if (held_valid_ff) begin
            mode_ff  <= mode_in;
            len_ff   <= len_in;
            kwbuf_ff <= kwbuf_in;
            acc_ff   <= acc_in;
            minus_ff <= minus_in;
            pos_ff   <= pos_in;
            tpos_ff  <= tpos_in;
         end
      end
   end

   assign bundle_push = accept && held_valid_ff && (cnt != 3'd0);
   assign bundle.cnt  = cnt;
   assign bundle.recs = recs;

endmodule

`default_nettype wire

// ----- hdl/sts_queue.sv -----
// ----------------------------------------------------------------------------
// SQL token scanner bundle queue
// Two-entry queue of result bundles between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_queue
   import sts_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  push,
   input  bundle_type push_data,
   output logic       full,
   input  wire logic  pop,
   output bundle_type head,
   output logic       empty
);

   bundle_type  mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign full  = count_ff == 2'd2;
   assign empty = count_ff == 2'd0;
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("bundle pushed into a full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("bundle popped from an empty queue");
   a_bundle_nonempty: assert property (@(posedge clock) disable iff (reset)
      push |-> push_data.cnt != 3'd0) else $error("empty bundle pushed");

endmodule

`default_nettype wire

// ----- hdl/sts_back.sv -----
// ----------------------------------------------------------------------------
// SQL token scanner back end
// Walks the records of the head bundle into the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_back
   import sts_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  bundle_type head,
   input  wire logic  head_empty,
   output logic       head_pop,
   input  wire logic  out_pop,
   output logic       out_valid,
   output rec_type    out_rec,
   output logic       out_final
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   rec_type    rec_ff;
   logic       final_ff;
   logic       load;
   logic       last;

   assign load = !valid_ff || out_pop;
   assign last = {1'b0, idx_ff} == (head.cnt - 3'd1);
   assign head_pop = load && !head_empty && last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = !head_empty;
         if (!head_empty) idx_in = last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && !head_empty) begin
         rec_ff   <= head.recs[idx_ff];
         final_ff <= last;
      end
   end

   assign out_valid = valid_ff;
   assign out_rec   = rec_ff;
   assign out_final = final_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      !head_empty |-> {1'b0, idx_ff} < head.cnt) else $error("record index past bundle");
   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      valid_ff && out_pop && !final_ff |=> valid_ff)
      else $error("bundle records lost between beats");
   a_idx_zero_when_empty: assert property (@(posedge clock) disable iff (reset)
      head_empty |-> idx_ff == 2'd0) else $error("stale record index");

endmodule

`default_nettype wire
